FILE: rtl/qsort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qsort_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned STACK_DEPTH  = 8;

endpackage

`default_nettype wire

FILE: rtl/qsort_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qsort_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [qsort_pkg::VALUE_W-1:0] value;
  logic                                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface qsort_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qsort_pkg::VALUE_W-1:0] value_res;
  logic                                last_res;
  logic                                dropped;

  modport source (output valid, output value_res, output last_res, output dropped,
                  input ready);
  modport sink   (input valid, input value_res, input last_res, input dropped,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/qsort_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module qsort_ram #(
  parameter int unsigned WIDTH = qsort_pkg::VALUE_W,
  parameter int unsigned DEPTH = qsort_pkg::CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/quicksort_block_sorter.sv
`timescale 1ns / 1ps
`default_nettype none

// Block quicksort of signed 32-bit values.
// in_i: one value per transfer, with last on the final value of a list. Values
// are written to the local store at one per cycle; values beyond CAPACITY are
// dropped and flagged. The transfer carrying last starts the sort, and in_i
// stays not ready until the whole sorted list has left on out_o.
// Sort: Hoare partitioning with the middle element as pivot, pending ranges on
// an 8-entry range stack. All store traffic goes through one RAM with a single
// registered read port: each partition pass sets up its range and reads the
// pivot, scans one element at a time from both ends, and swaps in two writes.
// out_o: one sorted value per transfer, ascending, with last_res on the final
// one and dropped set on all of them if any value of the list was discarded.
// Each value goes through a read, a load and a transfer state; a stalled
// receiver simply holds the block in its output state.
// Reset clears the fill count, the drop flag and the range stack pointer, and
// leaves the block idle and ready for the first value of a list.
module quicksort_block_sorter #(
  parameter int unsigned CAPACITY = qsort_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  qsort_in_if.sink      in_i,
  qsort_out_if.source   out_o
);

  localparam int unsigned IW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned SW  = IW + 2;
  localparam int unsigned SIW = $clog2(qsort_pkg::STACK_DEPTH);
  localparam int unsigned SPW = $clog2(qsort_pkg::STACK_DEPTH + 1);
  localparam int unsigned VW  = qsort_pkg::VALUE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_RANGE, S_PIV, S_SCANI, S_SCANJ, S_SWAP, S_DECIDE,
    S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic           ovf_q, ovf_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic           ovalid_q, ovalid_d;
  logic [CW-1:0]  n_q, n_d;
  logic [IW-1:0]  k_q, k_d;
  logic [IW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic signed [SW-1:0] i_q, i_d, j_q, j_d;
  logic signed [VW-1:0] pivot_q, pivot_d, vi_q, vi_d;
  logic signed [VW-1:0] oval_q, oval_d;
  logic           olast_q, olast_d, odrop_q, odrop_d;
  logic [IW-1:0]  st_lo_q [qsort_pkg::STACK_DEPTH];
  logic [IW-1:0]  st_hi_q [qsort_pkg::STACK_DEPTH];

  logic           st_we;
  logic [SIW-1:0] st_widx;
  logic [IW-1:0]  st_wlo, st_whi;

  logic           ram_we;
  logic [IW-1:0]  ram_waddr, ram_raddr;
  logic [VW-1:0]  ram_wdata, ram_rdata;

  logic signed [VW-1:0] rd_s;
  logic signed [SW-1:0] lo_s, hi_s, i_inc, j_dec, lsize, rsize;
  logic [IW:0]    mid_sum;
  logic [SPW-1:0] sp_m1;
  logic [SIW-1:0] st_ridx;
  logic           in_acc, cnt_lt, left_ok, right_ok;
  logic [CW-1:0]  cnt_inc, n_m1, n_new_m1;

  qsort_ram #(
    .WIDTH(VW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = ovalid_q;
  assign out_o.value_res = oval_q;
  assign out_o.last_res  = olast_q;
  assign out_o.dropped   = odrop_q;

  assign in_acc   = in_i.valid && (state_q == S_IDLE);
  assign rd_s     = $signed(ram_rdata);
  assign lo_s     = $signed({2'b00, lo_q});
  assign hi_s     = $signed({2'b00, hi_q});
  assign i_inc    = i_q + SW'(1);
  assign j_dec    = j_q - SW'(1);
  assign lsize    = j_q - lo_s;
  assign rsize    = hi_s - i_q;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign sp_m1    = sp_q - SPW'(1);
  assign st_ridx  = sp_m1[SIW-1:0];
  assign cnt_lt   = count_q < CW'(CAPACITY);
  assign cnt_inc  = count_q + CW'(1);
  assign n_m1     = n_q - CW'(1);
  assign n_new_m1 = count_d - CW'(1);
  assign left_ok  = lo_s < j_q;
  assign right_ok = i_q < hi_s;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    sp_d      = sp_q;
    ovalid_d  = ovalid_q;
    n_d       = n_q;
    k_d       = k_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    i_d       = i_q;
    j_d       = j_q;
    pivot_d   = pivot_q;
    vi_d      = vi_q;
    oval_d    = oval_q;
    olast_d   = olast_q;
    odrop_d   = odrop_q;
    st_we     = 1'b0;
    st_widx   = sp_q[SIW-1:0];
    st_wlo    = lo_q;
    st_whi    = hi_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[IW-1:0];
    ram_wdata = in_i.value;
    ram_raddr = k_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_lt) begin
            ram_we  = 1'b1;
            count_d = cnt_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last) begin
            n_d     = count_d;
            st_we   = 1'b1;
            st_widx = '0;
            st_wlo  = '0;
            st_whi  = n_new_m1[IW-1:0];
            sp_d    = (count_d > CW'(1)) ? SPW'(1) : '0;
            state_d = S_POP;
          end
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = S_EMIT_RD;
        end else begin
          sp_d    = sp_m1;
          lo_d    = st_lo_q[st_ridx];
          hi_d    = st_hi_q[st_ridx];
          state_d = S_RANGE;
        end
      end
      S_RANGE: begin
        if (lo_q < hi_q) begin
          i_d       = lo_s;
          j_d       = hi_s;
          ram_raddr = mid_sum[IW:1];
          state_d   = S_PIV;
        end else begin
          state_d = S_POP;
        end
      end
      S_PIV: begin
        pivot_d   = rd_s;
        ram_raddr = i_q[IW-1:0];
        state_d   = S_SCANI;
      end
      S_SCANI: begin
        if (rd_s < pivot_q) begin
          i_d       = i_inc;
          ram_raddr = i_inc[IW-1:0];
        end else begin
          vi_d      = rd_s;
          ram_raddr = j_q[IW-1:0];
          state_d   = S_SCANJ;
        end
      end
      S_SCANJ: begin
        if (pivot_q < rd_s) begin
          j_d       = j_dec;
          ram_raddr = j_dec[IW-1:0];
        end else if (i_q <= j_q) begin
          // first half of the swap: store[i] takes the value found at j
          ram_we    = 1'b1;
          ram_waddr = i_q[IW-1:0];
          ram_wdata = ram_rdata;
          state_d   = S_SWAP;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IW-1:0];
        ram_wdata = vi_q;
        i_d       = i_inc;
        j_d       = j_dec;
        ram_raddr = i_inc[IW-1:0];
        state_d   = (i_inc <= j_dec) ? S_SCANI : S_DECIDE;
      end
      S_DECIDE: begin
        if (left_ok && right_ok) begin
          // push the larger side while the stack has room, keep working on the smaller one
          if (sp_q < SPW'(qsort_pkg::STACK_DEPTH)) begin
            st_we = 1'b1;
            sp_d  = sp_q + SPW'(1);
          end
          if (lsize > rsize) begin
            st_wlo = lo_q;
            st_whi = j_q[IW-1:0];
            lo_d   = i_q[IW-1:0];
          end else begin
            st_wlo = i_q[IW-1:0];
            st_whi = hi_q;
            hi_d   = j_q[IW-1:0];
          end
          state_d = S_RANGE;
        end else if (left_ok) begin
          hi_d    = j_q[IW-1:0];
          state_d = S_RANGE;
        end else if (right_ok) begin
          lo_d    = i_q[IW-1:0];
          state_d = S_RANGE;
        end else begin
          state_d = S_POP;
        end
      end
      S_EMIT_RD: begin
        ram_raddr = k_q;
        state_d   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        oval_d   = rd_s;
        olast_d  = (CW'(k_q) == n_m1);
        odrop_d  = ovf_q;
        ovalid_d = 1'b1;
        state_d  = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_o.ready) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            sp_d    = '0;
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + IW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      sp_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      sp_q     <= sp_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    k_q     <= k_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    j_q     <= j_d;
    pivot_q <= pivot_d;
    vi_q    <= vi_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
    odrop_q <= odrop_d;
    if (st_we) begin
      st_lo_q[st_widx] <= st_wlo;
      st_hi_q[st_widx] <= st_whi;
    end
  end

`ifndef SYNTHESIS
  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> !in_i.ready)
    else $error("input ready while a sorted value is pending");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(qsort_pkg::STACK_DEPTH))
    else $error("range stack pointer beyond its depth");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCANI) |-> (i_q >= lo_s && i_q <= hi_s))
    else $error("left scan left its range");

  a_clear_after_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_o.ready && olast_q) |=> (count_q == '0 && !ovf_q))
    else $error("list state not cleared after final transfer");
`endif

endmodule

`default_nettype wire

FILE: bench/sorted_list_checker.sv
`timescale 1ns / 1ps

module sorted_list_checker #(
  parameter int unsigned CAPACITY = qsort_pkg::CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  qsort_in_if  in_mon,
  qsort_out_if out_mon,
  output int   fail_count,
  output int   sorted_left
);

  typedef logic signed [qsort_pkg::VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   dropped;
  } sorted_entry_t;

  value_t        list_vals[$];
  sorted_entry_t sorted_q[$];
  logic          list_overflowed;

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_entry_t want;
    value_t        key;
    int            j;
    if (!rst_ni) begin
      list_vals.delete();
      sorted_q.delete();
      list_overflowed = 1'b0;
      fail_count      = 0;
      sorted_left     = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected result: value_res %0d last_res %0b dropped %0b",
                 $signed(out_mon.value_res), out_mon.last_res, out_mon.dropped);
          fail_count++;
        end else begin
          want = sorted_q.pop_front();
          if (out_mon.value_res !== want.value) begin
            $error("value_res: expected %0d, got %0d", $signed(want.value),
                   $signed(out_mon.value_res));
            fail_count++;
          end
          if (out_mon.last_res !== want.last) begin
            $error("last_res: expected %0b, got %0b", want.last, out_mon.last_res);
            fail_count++;
          end
          if (out_mon.dropped !== want.dropped) begin
            $error("dropped: expected %0b, got %0b", want.dropped, out_mon.dropped);
            fail_count++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        // drop values once the store is full, but remember it for the whole list
        if (list_vals.size() < CAPACITY) list_vals.push_back(in_mon.value);
        else list_overflowed = 1'b1;

        if (in_mon.last) begin
          // any correct sort yields the same ascending multiset as the quicksort
          for (int i = 1; i < list_vals.size(); i++) begin
            key = list_vals[i];
            j   = i;
            while (j > 0 && list_vals[j-1] > key) begin
              list_vals[j] = list_vals[j-1];
              j--;
            end
            list_vals[j] = key;
          end
          foreach (list_vals[k]) begin
            want.value   = list_vals[k];
            want.last    = (k == list_vals.size() - 1);
            want.dropped = list_overflowed;
            sorted_q.push_back(want);
          end
          list_vals.delete();
          list_overflowed = 1'b0;
        end
      end

      sorted_left = sorted_q.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CAPACITY    = qsort_pkg::CAPACITY_DEF;
  localparam int          STALL_LIMIT = 20000;
  localparam int          HOLD_CYCLES = 400;

  typedef logic signed [qsort_pkg::VALUE_W-1:0] value_t;

  localparam value_t VAL_MIN = {1'b1, {(qsort_pkg::VALUE_W-1){1'b0}}};
  localparam value_t VAL_MAX = {1'b0, {(qsort_pkg::VALUE_W-1){1'b1}}};

  logic clk_i;
  logic rst_ni;

  qsort_in_if  in_ch ();
  qsort_out_if out_ch ();

  int fail_count;
  int sorted_left;
  int send_gap_pct;
  int recv_stall_pct;
  int items_sent;
  int idle_cycles;
  int hold_left;
  bit hold_request;

  quicksort_block_sorter #(
    .CAPACITY (CAPACITY)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sorted_list_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .sorted_left (sorted_left)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic value_t pick_value();
    case ($urandom_range(3))
      0, 1: return $urandom;
      2: return int'($urandom_range(8)) - 4;
      default: begin
        case ($urandom_range(3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic send_value(input value_t v, input logic is_last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_list(input int len, input bit hold_out);
    for (int k = 0; k < len; k++) begin
      if (hold_out && k == len - 1) hold_request = 1'b1;
      send_value(pick_value(), k == len - 1);
    end
  endtask

  task automatic send_random_lists(input int target);
    while (items_sent < target) begin
      send_list(($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10), 1'b0);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sorted_left != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    in_ch.last     = 1'b0;
    hold_request   = 1'b0;
    idle_cycles    = 0;
    items_sent     = 0;
    send_gap_pct   = 20;
    recv_stall_pct = 76;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single value, extremes with repeats, all equal, ascending, descending, pair
    send_value(VAL_MAX, 1'b1);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value('0, 1'b0);
    send_value('1, 1'b0);
    send_value(1, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX, 1'b1);
    repeat (3) send_value(42, 1'b0);
    send_value(42, 1'b1);
    for (int k = 0; k < 4; k++) send_value(k - 1, k == 3);
    for (int k = 0; k < 4; k++) send_value(3 - 2 * k, k == 3);
    send_value(32'h5555_5555, 1'b0);
    send_value(32'hAAAA_AAAA, 1'b1);
    send_random_lists(70);
    drain_results();

    send_gap_pct   = 76;
    recv_stall_pct = 20;
    // hold the output so the block stalls its input while the next list waits
    send_list(20, 1'b1);
    send_random_lists(130);
    drain_results();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    // fill the store exactly, then drop the item carrying last
    send_list(CAPACITY + 1, 1'b0);
    send_random_lists(210);
    drain_results();

    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && sorted_left == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/qsort_pkg.sv
rtl/qsort_if.sv
rtl/qsort_ram.sv
rtl/quicksort_block_sorter.sv
bench/sorted_list_checker.sv
bench/tb_top.sv
